@@ src/pfe_pkg.sv @@
// Shared types and constants of the postfix expression evaluator.
// Holds operation and status codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package pfe_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int ST_W            = 2;
    localparam int STACK_DEPTH_DEF = 128;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_TOP    = 2'd1,
        RD_SECOND = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load_in;
        logic    push;
        t_rd_sel rd_sel;
        logic    cap_right;
        logic    cap_left;
        logic    exec;
        logic    div_start;
        logic    div_take;
        logic    write_res;
        logic    note_err;
        t_status err_code;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic eoe;
        logic full;
        logic lt2;
        logic right_zero;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ src/pfe_if.sv @@
// Handshake channel interfaces of the postfix expression evaluator.
// One interface for the token channel and one for the result channel.
// Depends on pfe_pkg.
`default_nettype none

interface pfe_in_if;
    logic                              valid;
    logic                              ready;
    logic [pfe_pkg::OP_W-1:0]          operation;
    logic signed [pfe_pkg::DATA_W-1:0] value;
    logic                              end_of_expression;

    modport source (output valid, output operation, output value,
                    output end_of_expression, input ready);
    modport sink   (input valid, input operation, input value,
                    input end_of_expression, output ready);
endinterface

interface pfe_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pfe_pkg::DATA_W-1:0] answer;
    logic [pfe_pkg::ST_W-1:0]          status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

`default_nettype wire

@@ src/postfix_expression_evaluator.sv @@
// Postfix (reverse Polish) integer expression evaluator, one token per input transaction.
// A push token places a signed 32-bit operand on a stack of STACK_DEPTH entries; an operator
// pops two entries and pushes second OP top with two's complement wrap. A token marked end of
// expression produces one result transaction with the top value and the first error seen in
// the expression, then empties the stack. Tokens are taken one at a time: a push, an unknown
// code or an operator that finds fewer than two entries is handled in the decode step; add,
// subtract, multiply and a divide by zero make two stack memory reads and a write, and divide
// also waits for the one-bit-per-cycle divider; end of expression adds the result load, which
// waits while the result register is still waiting to be taken.
// Depends on pfe_pkg, pfe_if, pfe_controller and pfe_datapath.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pfe_in_if.sink    i_tok,
    pfe_out_if.source o_res
);
    import pfe_pkg::*;

    t_dp_cmd c_cmd;
    t_dp_sts c_sts;
    logic    c_in_ready;

    pfe_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .o_in_ready (c_in_ready),
        .i_sts      (c_sts),
        .o_cmd      (c_cmd)
    );

    pfe_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (c_cmd),
        .o_sts               (c_sts),
        .i_operation         (i_tok.operation),
        .i_value             (i_tok.value),
        .i_end_of_expression (i_tok.end_of_expression),
        .i_out_ready         (o_res.ready),
        .o_out_valid         (o_res.valid),
        .o_answer            (o_res.answer),
        .o_status            (o_res.status)
    );

    assign i_tok.ready = c_in_ready;

    a_one_token_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && i_tok.ready) |=> !i_tok.ready)
        else $error("token accepted while the previous one was still in progress");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.push |-> !c_sts.full)
        else $error("push issued onto a full stack");

    a_no_div_by_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.div_start |-> !c_sts.right_zero)
        else $error("divider started with a zero divisor");

    a_result_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_cmd.load_out |=> o_res.valid)
        else $error("result load did not present a result transaction");

endmodule

`default_nettype wire

@@ src/pfe_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Works on magnitudes and fixes the sign at the end; the result wraps to 32 bits.
// Depends on pfe_pkg.
`default_nettype none

module pfe_divider (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pfe_pkg::DATA_W-1:0]   i_dividend,
    input  wire logic [pfe_pkg::DATA_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [pfe_pkg::DATA_W-1:0]        o_quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;

    assign abs_a  = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
    assign abs_b  = i_divisor[DATA_W-1]  ? (~i_divisor + DATA_W'(1))  : i_divisor;
    assign rem_sh = {r_rem, r_quo[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= abs_a;
            r_dvs <= abs_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

endmodule

`default_nettype wire

@@ src/pfe_datapath.sv @@
// Datapath of the postfix expression evaluator: token register, operand stack memory,
// arithmetic unit, sticky status and the result register. Depends on pfe_pkg and pfe_divider.
`default_nettype none

module pfe_datapath #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pfe_pkg::t_dp_cmd                  i_cmd,
    output pfe_pkg::t_dp_sts                       o_sts,
    input  wire logic [pfe_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [pfe_pkg::DATA_W-1:0] i_value,
    input  wire logic                              i_end_of_expression,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [pfe_pkg::DATA_W-1:0]      o_answer,
    output logic [pfe_pkg::ST_W-1:0]               o_status
);
    import pfe_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;
    t_op               r_op;
    logic [DATA_W-1:0] r_value;
    logic              r_eoe;
    logic [CW-1:0]     r_count;
    t_status           r_err;
    logic [DATA_W-1:0] r_right;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_res;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_answer;
    t_status           r_status;

    logic [CW-1:0]     count_m1;
    logic [CW-1:0]     count_m2;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] alu_res;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    assign count_m1 = r_count - CW'(1);
    assign count_m2 = r_count - CW'(2);
    assign raddr    = (i_cmd.rd_sel == RD_SECOND) ? count_m2[AW-1:0] : count_m1[AW-1:0];
    assign waddr    = i_cmd.push ? r_count[AW-1:0] : count_m2[AW-1:0];
    assign wdata    = i_cmd.push ? r_value : r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.write_res) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_sel != RD_NONE) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_comb begin
        case (r_op)
            OP_ADD:  alu_res = r_left + r_right;
            OP_SUB:  alu_res = r_left - r_right;
            OP_MUL:  alu_res = r_left * r_right;
            default: alu_res = '0;
        endcase
    end

    pfe_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_left),
        .i_divisor  (r_right),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= t_op'(i_operation);
            r_value <= i_value;
            r_eoe   <= i_end_of_expression;
        end
        if (i_cmd.cap_right) begin
            r_right <= r_rdata;
        end
        if (i_cmd.cap_left) begin
            r_left <= r_rdata;
        end
        if (i_cmd.exec) begin
            r_res <= alu_res;
        end else if (i_cmd.div_take) begin
            r_res <= div_quo;
        end
        if (i_cmd.load_out) begin
            r_answer <= (r_count == '0) ? '0 : r_rdata;
            r_status <= ((r_count == '0) && (r_err == ST_OK)) ? ST_UNDERFLOW : r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_count <= '0;
                r_err   <= ST_OK;
            end else begin
                if (i_cmd.push) begin
                    r_count <= r_count + CW'(1);
                end else if (i_cmd.write_res) begin
                    r_count <= count_m1;
                end
                if (i_cmd.note_err && (r_err == ST_OK)) begin
                    r_err <= i_cmd.err_code;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.eoe        = r_eoe;
    assign o_sts.full       = (r_count >= CW'(STACK_DEPTH));
    assign o_sts.lt2        = (r_count < CW'(2));
    assign o_sts.right_zero = (r_right == '0);
    assign o_sts.div_done   = div_done;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

endmodule

`default_nettype wire

@@ src/pfe_controller.sv @@
// Controller state machine of the postfix expression evaluator.
// Sequences each token through the datapath by command and status structs. Depends on pfe_pkg.
`default_nettype none

module pfe_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire pfe_pkg::t_dp_sts i_sts,
    output pfe_pkg::t_dp_cmd      o_cmd
);
    import pfe_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_RD_R   = 10'b00_0000_0100,
        S_RD_L   = 10'b00_0000_1000,
        S_GET_L  = 10'b00_0001_0000,
        S_EXEC   = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_WRITE  = 10'b00_1000_0000,
        S_FINISH = 10'b01_0000_0000,
        S_RESULT = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                unique case (i_sts.op) inside
                    OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.note_err = 1'b1;
                            o_cmd.err_code = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (i_sts.lt2) begin
                            o_cmd.note_err = 1'b1;
                            o_cmd.err_code = ST_UNDERFLOW;
                        end else begin
                            n_state = S_RD_R;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_RD_R: begin
                o_cmd.rd_sel = RD_TOP;
                n_state      = S_RD_L;
            end
            S_RD_L: begin
                o_cmd.rd_sel    = RD_SECOND;
                o_cmd.cap_right = 1'b1;
                n_state         = S_GET_L;
            end
            S_GET_L: begin
                o_cmd.cap_left = 1'b1;
                n_state        = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op != OP_DIV) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_WRITE;
                end else if (i_sts.right_zero) begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.note_err = 1'b1;
                    o_cmd.err_code = ST_DIVZERO;
                    n_state        = S_WRITE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_res = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.eoe) begin
                    o_cmd.rd_sel = RD_TOP;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ sim/postfix_expression_evaluator_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the postfix expression evaluator: directed and random token streams
// are checked against a stack evaluator kept in the bench, one expected result per expression.
// Depends on pfe_pkg, pfe_if and postfix_expression_evaluator.

module postfix_expression_evaluator_test;
    import pfe_pkg::*;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int RANDOM_TOKENS = 1950;
    localparam int TAIL_TOKENS   = 150;
    localparam int MAX_PRINTED   = 100;

    localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic                     eoe;
    } t_token;

    typedef struct {
        logic signed [DATA_W-1:0] answer;
        t_status                  status;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    pfe_in_if  tok_if();
    pfe_out_if res_if();

    postfix_expression_evaluator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    t_token                   token_queue[$];
    t_outcome                 expected_outcomes[$];
    logic signed [DATA_W-1:0] eval_stack[DEPTH];
    int                       eval_depth = 0;
    t_status                  eval_status = ST_OK;

    int       mismatch_count = 0;
    int       issued_tokens = 0;
    bit       tok_taken = 1'b0;
    int       tok_gap = 0;
    int       res_stall = 0;
    bit       tok_calm = 1'b0;
    bit       res_calm = 1'b0;
    t_token   next_token;
    t_outcome oldest;

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTED)
            $display("tb: mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void note_status(t_status code);
        if (eval_status == ST_OK)
            eval_status = code;
    endfunction

    function automatic void evaluate_token(t_token t);
        logic [DATA_W-1:0] lhs, rhs, res;
        longint            quotient;
        t_outcome          outcome;
        if (t.operation == OP_PUSH) begin
            if (eval_depth >= DEPTH) begin
                note_status(ST_OVERFLOW);
            end else begin
                eval_stack[eval_depth] = t.value;
                eval_depth++;
            end
        end else if (t.operation <= OP_DIV) begin
            if (eval_depth < 2) begin
                note_status(ST_UNDERFLOW);
            end else begin
                rhs = eval_stack[eval_depth-1];
                lhs = eval_stack[eval_depth-2];
                eval_depth -= 2;
                case (t.operation)
                    OP_ADD: res = lhs + rhs;
                    OP_SUB: res = lhs - rhs;
                    OP_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            note_status(ST_DIVZERO);
                            res = '0;
                        end else begin
                            quotient = longint'($signed(lhs)) / longint'($signed(rhs));
                            res = quotient[DATA_W-1:0];
                        end
                    end
                endcase
                eval_stack[eval_depth] = res;
                eval_depth++;
            end
        end
        if (t.eoe) begin
            outcome.answer = '0;
            if (eval_depth == 0)
                note_status(ST_UNDERFLOW);
            else
                outcome.answer = eval_stack[eval_depth-1];
            outcome.status = eval_status;
            expected_outcomes.push_back(outcome);
            eval_depth = 0;
            eval_status = ST_OK;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return int'($urandom_range(0, 8)) - 4;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return INT_MIN;
                    1:       return INT_MAX;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    function automatic void queue_token(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                        bit eoe);
        token_queue.push_back(t_token'{op, value, eoe});
        if (op <= OP_DIV)
            issued_tokens++;
    endfunction

    // Builds a well-formed expression with the given number of operands, ending in one value.
    function automatic void queue_formula(int operands, bit operands_first);
        int              depth_now = 0;
        int              remaining = operands;
        logic [OP_W-1:0] op;
        logic signed [DATA_W-1:0] value;
        while (remaining > 0 || depth_now > 1) begin
            if (depth_now >= 2 &&
                (remaining == 0 || (!operands_first && $urandom_range(0, 2) == 0))) begin
                op = OP_W'($urandom_range(OP_ADD, OP_DIV));
                value = $urandom;
                depth_now--;
            end else begin
                op = OP_PUSH;
                value = pick_operand();
                depth_now++;
                remaining--;
            end
            queue_token(op, value, remaining == 0 && depth_now == 1);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int kind;
        int n;
        i_rst_n = 1'b0;
        tok_if.valid = 1'b0;
        tok_if.operation = OP_PUSH;
        tok_if.value = '0;
        tok_if.end_of_expression = 1'b0;
        res_if.ready = 1'b0;

        queue_token(OP_PUSH, INT_MAX, 1'b0);
        queue_token(OP_PUSH, 1, 1'b0);
        queue_token(OP_ADD, 0, 1'b1);
        queue_token(OP_PUSH, INT_MIN, 1'b0);
        queue_token(OP_PUSH, 1, 1'b0);
        queue_token(OP_SUB, 0, 1'b1);
        queue_token(OP_PUSH, INT_MIN, 1'b0);
        queue_token(OP_PUSH, -1, 1'b0);
        queue_token(OP_DIV, -1, 1'b1);
        queue_token(OP_PUSH, 7, 1'b0);
        queue_token(OP_PUSH, -2, 1'b0);
        queue_token(OP_DIV, 0, 1'b1);
        queue_token(OP_PUSH, 65536, 1'b0);
        queue_token(OP_PUSH, -65537, 1'b0);
        queue_token(OP_MUL, 0, 1'b1);
        queue_token(OP_ADD, INT_MAX, 1'b1);
        // The first error of an expression is kept even when a later divide by zero follows.
        queue_token(OP_PUSH, 1, 1'b0);
        queue_token(OP_ADD, 0, 1'b0);
        queue_token(OP_PUSH, 0, 1'b0);
        queue_token(OP_DIV, 0, 1'b1);
        queue_token(OP_PUSH, 3, 1'b0);
        queue_token(OP_W'(OP_DIV + 1), INT_MIN, 1'b0);
        queue_token(OP_SPARE_LAST, -1, 1'b1);
        queue_token(OP_PUSH, -1, 1'b1);
        queue_token(OP_W'(OP_SPARE_LAST - 1), 0, 1'b1);

        issued_tokens = 0;
        while (issued_tokens < RANDOM_TOKENS) begin
            kind = $urandom_range(0, 99);
            if (kind < 1) begin
                queue_formula(DEPTH, 1'b1);
            end else if (kind < 2) begin
                n = DEPTH + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    queue_token(OP_PUSH, pick_operand(), i == n - 1);
            end else if (kind < 7) begin
                queue_formula($urandom_range(13, 60), $urandom_range(0, 1) == 1);
            end else if (kind < 80) begin
                queue_formula($urandom_range(1, 12), $urandom_range(0, 1) == 1);
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    queue_token(OP_W'($urandom_range(OP_PUSH, OP_SPARE_LAST)), $urandom,
                                i == n - 1 || $urandom_range(0, 5) == 0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (token_queue.size() != 0 || tok_if.valid || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok_if.valid <= 1'b0;
        end else if (!tok_if.valid || tok_taken) begin
            if (tok_gap > 0) begin
                tok_gap--;
                tok_if.valid <= 1'b0;
            end else if (token_queue.size() != 0) begin
                next_token = token_queue.pop_front();
                tok_if.operation <= next_token.operation;
                tok_if.value <= next_token.value;
                tok_if.end_of_expression <= next_token.eoe;
                tok_if.valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    tok_calm = !tok_calm;
                if (!tok_calm && token_queue.size() > TAIL_TOKENS && $urandom_range(0, 4) == 0)
                    tok_gap = $urandom_range(1, 18);
            end else begin
                tok_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (res_stall > 0) begin
            res_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                res_calm = !res_calm;
            if (!res_calm && token_queue.size() > TAIL_TOKENS && $urandom_range(0, 9) == 0)
                res_stall = $urandom_range(1, 18);
        end
    end

    always @(posedge i_clk) begin
        tok_taken = i_rst_n && tok_if.valid && tok_if.ready;
        if (tok_taken)
            evaluate_token(t_token'{tok_if.operation, tok_if.value, tok_if.end_of_expression});
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch($sformatf("result answer %0d status %0d with none expected",
                                          res_if.answer, res_if.status));
            end else begin
                oldest = expected_outcomes.pop_front();
                if (res_if.answer !== oldest.answer)
                    report_mismatch($sformatf("answer %0d, expected %0d",
                                              res_if.answer, oldest.answer));
                if (res_if.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              res_if.status, oldest.status.name()));
            end
        end
    end

endmodule

@@ filelist.f @@
src/pfe_pkg.sv
src/pfe_if.sv
src/pfe_divider.sv
src/pfe_datapath.sv
src/pfe_controller.sv
src/postfix_expression_evaluator.sv
sim/postfix_expression_evaluator_test.sv
